// ----- sv/backtracking_path_search_top_macros.svh -----
// Assertion macros for the backtracking path search block.
// Used by the port checker; no other dependencies.
`ifndef BACKTRACKING_PATH_SEARCH_TOP_MACROS_SVH
`define BACKTRACKING_PATH_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define BPS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bps_pkg.sv -----
// Shared types, constants and the microcode ROM of the backtracking path search.
// No dependencies; used by the top level and the port checker.
package bps_pkg;

   localparam int MAX_EDGES  = 32;
   localparam int NODE_COUNT = 64;
   localparam int NODE_W     = 6;
   localparam int IDX_W      = $clog2(MAX_EDGES);
   localparam int CNT_W      = $clog2(MAX_EDGES + 1);

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // Command codes (code 3 is unused and ignored)
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      node_type   from_node;
      node_type   to_node;
   } req_type;

   typedef struct packed {
      logic     found;
      node_type step_from;
      node_type step_to;
      logic     last;
   } rsp_type;

   // One table edge or one stack entry
   typedef struct packed {
      node_type src;
      node_type tgt;
   } link_type;

   // Microprogram steps
   typedef enum logic [4:0] {
      S_IDLE      = 5'd0,
      S_G_INIT    = 5'd1,
      S_G_READ    = 5'd2,
      S_G_TEST    = 5'd3,
      S_G_NEXT    = 5'd4,
      S_F_INIT    = 5'd5,
      S_F_READ    = 5'd6,
      S_F_TEST    = 5'd7,
      S_F_NEXT    = 5'd8,
      S_POP       = 5'd9,
      S_POP_SET   = 5'd10,
      S_MOVE      = 5'd11,
      S_PUSH_GOAL = 5'd12,
      S_E_INIT    = 5'd13,
      S_E_READ    = 5'd14,
      S_E_SEND    = 5'd15,
      S_E_NEXT    = 5'd16,
      S_E_LOOP    = 5'd17,
      S_FAIL      = 5'd18,
      S_FINISH    = 5'd19
   } step_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SCAN_TOP,
      OP_READ_DOWN,
      OP_SCAN_ZERO,
      OP_READ_UP,
      OP_SCAN_INC,
      OP_POP_READ,
      OP_CUR_FROM_STACK,
      OP_PUSH_EDGE,
      OP_PUSH_GOAL,
      OP_READ_STACK,
      OP_EMIT,
      OP_EMIT_FAIL
   } op_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_SEARCH,
      C_COUNT_ZERO,
      C_GOAL_HIT,
      C_SCAN_NZ,
      C_FWD_HIT,
      C_MORE_EDGES,
      C_DEPTH_ZERO,
      C_SEND_WAIT,
      C_OUT_DONE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // Node ids are reduced into the node range
   function automatic node_type node_id(node_type v);
      return node_type'(32'(v) % NODE_COUNT);
   endfunction

   // Microcode ROM: operation, jump condition and jump target per step
   function automatic uword_type micro_rom(step_type s);
      uword_type w;
      w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
      unique case (s)
         S_IDLE:      w = '{op: OP_ACCEPT,         cond: C_NO_SEARCH,  target: S_IDLE};
         S_G_INIT:    w = '{op: OP_SCAN_TOP,       cond: C_COUNT_ZERO, target: S_F_INIT};
         S_G_READ:    w = '{op: OP_READ_DOWN,      cond: C_NEVER,      target: S_IDLE};
         S_G_TEST:    w = '{op: OP_NONE,           cond: C_GOAL_HIT,   target: S_PUSH_GOAL};
         S_G_NEXT:    w = '{op: OP_NONE,           cond: C_SCAN_NZ,    target: S_G_READ};
         S_F_INIT:    w = '{op: OP_SCAN_ZERO,      cond: C_COUNT_ZERO, target: S_POP};
         S_F_READ:    w = '{op: OP_READ_UP,        cond: C_NEVER,      target: S_IDLE};
         S_F_TEST:    w = '{op: OP_NONE,           cond: C_FWD_HIT,    target: S_MOVE};
         S_F_NEXT:    w = '{op: OP_SCAN_INC,       cond: C_MORE_EDGES, target: S_F_READ};
         S_POP:       w = '{op: OP_POP_READ,       cond: C_DEPTH_ZERO, target: S_FAIL};
         S_POP_SET:   w = '{op: OP_CUR_FROM_STACK, cond: C_ALWAYS,     target: S_G_INIT};
         S_MOVE:      w = '{op: OP_PUSH_EDGE,      cond: C_ALWAYS,     target: S_G_INIT};
         S_PUSH_GOAL: w = '{op: OP_PUSH_GOAL,      cond: C_NEVER,      target: S_IDLE};
         S_E_INIT:    w = '{op: OP_SCAN_ZERO,      cond: C_DEPTH_ZERO, target: S_FAIL};
         S_E_READ:    w = '{op: OP_READ_STACK,     cond: C_NEVER,      target: S_IDLE};
         S_E_SEND:    w = '{op: OP_EMIT,           cond: C_SEND_WAIT,  target: S_E_SEND};
         S_E_NEXT:    w = '{op: OP_SCAN_INC,       cond: C_OUT_DONE,   target: S_IDLE};
         S_E_LOOP:    w = '{op: OP_NONE,           cond: C_ALWAYS,     target: S_E_READ};
         S_FAIL:      w = '{op: OP_EMIT_FAIL,      cond: C_SEND_WAIT,  target: S_FAIL};
         S_FINISH:    w = '{op: OP_NONE,           cond: C_ALWAYS,     target: S_IDLE};
         default:     w = '{op: OP_NONE,           cond: C_ALWAYS,     target: S_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- sv/backtracking_path_search_top.sv -----
// Backtracking path search. Loads, clears and ignored commands finish in the idle step.
// A search runs at most 2*n+1 search steps (n = edges held); each is a goal scan, then a
// forward scan with its move or pop, as the single edge RAM read port is walked one entry
// per three microcode steps; each path word then runs the read, send, next and loop steps,
// with send held while the receiver stalls. Reset clears edge count, stack depth,
// skip marks and the step counter; table and stack contents are undefined until written.
module backtracking_path_search_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bps_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bps_pkg::rsp_type  rsp_data
);

   // sequencer
   bps_pkg::step_type  upc_ff, upc_in;
   bps_pkg::uword_type uword;

   // datapath registers
   bps_pkg::cnt_type                  count_ff, count_in;
   bps_pkg::cnt_type                  depth_ff, depth_in;
   bps_pkg::cnt_type                  scan_ff, scan_in;
   logic [bps_pkg::MAX_EDGES-1:0]     used_ff, used_in;
   bps_pkg::node_type                 cur_ff, cur_in;
   bps_pkg::node_type                 goal_ff, goal_in;

   // memories
   logic              edge_wr_en, edge_rd_en;
   bps_pkg::idx_type  edge_wr_addr, edge_rd_addr;
   bps_pkg::link_type edge_wr_data, edge_rd_data;
   logic              stack_wr_en, stack_rd_en;
   bps_pkg::idx_type  stack_wr_addr, stack_rd_addr;
   bps_pkg::link_type stack_wr_data, stack_rd_data;

   // decode helpers
   logic              req_fire;
   logic              cond_true;
   logic              goal_hit, fwd_hit;
   bps_pkg::idx_type  scan_idx;
   bps_pkg::cnt_type  scan_plus, scan_minus, depth_minus;
   logic              depth_room;

   assign uword       = bps_pkg::micro_rom(upc_ff);
   assign req_stall   = (uword.op != bps_pkg::OP_ACCEPT);
   assign req_fire    = req_valid && !req_stall;
   assign scan_idx    = scan_ff[bps_pkg::IDX_W-1:0];
   assign scan_plus   = bps_pkg::CNT_W'(scan_ff + bps_pkg::CNT_W'(1));
   assign scan_minus  = bps_pkg::CNT_W'(scan_ff - bps_pkg::CNT_W'(1));
   assign depth_minus = bps_pkg::CNT_W'(depth_ff - bps_pkg::CNT_W'(1));
   assign depth_room  = (depth_ff < bps_pkg::CNT_W'(bps_pkg::MAX_EDGES));

   // edge comparisons against the word read last cycle
   assign fwd_hit  = (edge_rd_data.src == cur_ff) && !used_ff[scan_idx];
   assign goal_hit = fwd_hit && (edge_rd_data.tgt == goal_ff);

   // jump condition select
   always_comb begin
      unique case (uword.cond)
         bps_pkg::C_NEVER:      cond_true = 1'b0;
         bps_pkg::C_ALWAYS:     cond_true = 1'b1;
         bps_pkg::C_NO_SEARCH:  cond_true = !(req_fire &&
                                            (req_data.command == bps_pkg::CMD_SEARCH));
         bps_pkg::C_COUNT_ZERO: cond_true = (count_ff == '0);
         bps_pkg::C_GOAL_HIT:   cond_true = goal_hit;
         bps_pkg::C_SCAN_NZ:    cond_true = (scan_ff != '0);
         bps_pkg::C_FWD_HIT:    cond_true = fwd_hit;
         bps_pkg::C_MORE_EDGES: cond_true = (scan_plus != count_ff);
         bps_pkg::C_DEPTH_ZERO: cond_true = (depth_ff == '0);
         bps_pkg::C_SEND_WAIT:  cond_true = rsp_stall;
         bps_pkg::C_OUT_DONE:   cond_true = (scan_plus == depth_ff);
         default:               cond_true = 1'b1;
      endcase
   end

   // next step: jump target or fall through
   always_comb begin
      if (cond_true) begin
         upc_in = uword.target;
      end else begin
         upc_in = bps_pkg::step_type'(5'(upc_ff + 5'd1));
      end
   end

   // datapath control from the current control word
   always_comb begin
      count_in      = count_ff;
      depth_in      = depth_ff;
      scan_in       = scan_ff;
      used_in       = used_ff;
      cur_in        = cur_ff;
      goal_in       = goal_ff;
      edge_wr_en    = 1'b0;
      edge_wr_addr  = count_ff[bps_pkg::IDX_W-1:0];
      edge_wr_data  = '{src: bps_pkg::node_id(req_data.from_node),
                        tgt: bps_pkg::node_id(req_data.to_node)};
      edge_rd_en    = 1'b0;
      edge_rd_addr  = scan_idx;
      stack_wr_en   = 1'b0;
      stack_wr_addr = depth_ff[bps_pkg::IDX_W-1:0];
      stack_wr_data = '{src: cur_ff, tgt: goal_ff};
      stack_rd_en   = 1'b0;
      stack_rd_addr = scan_idx;
      rsp_valid     = 1'b0;
      rsp_data      = '{found: 1'b0, step_from: '0, step_to: '0, last: 1'b1};
      unique case (uword.op)
         bps_pkg::OP_NONE: begin
         end
         // command decode in the idle step
         bps_pkg::OP_ACCEPT: begin
            if (req_fire) begin
               priority if (req_data.command == bps_pkg::CMD_LOAD) begin
                  if (count_ff < bps_pkg::CNT_W'(bps_pkg::MAX_EDGES)) begin
                     edge_wr_en = 1'b1;
                     count_in   = bps_pkg::CNT_W'(count_ff + bps_pkg::CNT_W'(1));
                  end
               end else if (req_data.command == bps_pkg::CMD_CLEAR) begin
                  count_in = '0;
               end else if (req_data.command == bps_pkg::CMD_SEARCH) begin
                  cur_in   = bps_pkg::node_id(req_data.from_node);
                  goal_in  = bps_pkg::node_id(req_data.to_node);
                  used_in  = '0;
                  depth_in = '0;
               end else begin
               end
            end
         end
         bps_pkg::OP_SCAN_TOP:  scan_in = count_ff;
         bps_pkg::OP_READ_DOWN: begin
            edge_rd_en   = 1'b1;
            edge_rd_addr = scan_minus[bps_pkg::IDX_W-1:0];
            scan_in      = scan_minus;
         end
         bps_pkg::OP_SCAN_ZERO: scan_in = '0;
         bps_pkg::OP_READ_UP:   edge_rd_en = 1'b1;
         bps_pkg::OP_SCAN_INC:  scan_in = scan_plus;
         // backtrack: drop the top entry, resume from its source
         bps_pkg::OP_POP_READ: begin
            if (depth_ff != '0) begin
               stack_rd_en   = 1'b1;
               stack_rd_addr = depth_minus[bps_pkg::IDX_W-1:0];
               depth_in      = depth_minus;
            end
         end
         bps_pkg::OP_CUR_FROM_STACK: cur_in = stack_rd_data.src;
         // take the edge found by the forward scan
         bps_pkg::OP_PUSH_EDGE: begin
            used_in[scan_idx] = 1'b1;
            cur_in            = edge_rd_data.tgt;
            stack_wr_data     = '{src: cur_ff, tgt: edge_rd_data.tgt};
            if (depth_room) begin
               stack_wr_en = 1'b1;
               depth_in    = bps_pkg::CNT_W'(depth_ff + bps_pkg::CNT_W'(1));
            end
         end
         bps_pkg::OP_PUSH_GOAL: begin
            if (depth_room) begin
               stack_wr_en = 1'b1;
               depth_in    = bps_pkg::CNT_W'(depth_ff + bps_pkg::CNT_W'(1));
            end
         end
         bps_pkg::OP_READ_STACK: stack_rd_en = 1'b1;
         // path word out of the stack, oldest first
         bps_pkg::OP_EMIT: begin
            rsp_valid = 1'b1;
            rsp_data  = '{found: 1'b1, step_from: stack_rd_data.src,
                          step_to: stack_rd_data.tgt, last: (scan_plus == depth_ff)};
         end
         bps_pkg::OP_EMIT_FAIL: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff   <= bps_pkg::S_IDLE;
         count_ff <= '0;
         depth_ff <= '0;
         scan_ff  <= '0;
         used_ff  <= '0;
      end else begin
         upc_ff   <= upc_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
         scan_ff  <= scan_in;
         used_ff  <= used_in;
      end
   end

   // search node registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      goal_ff <= goal_in;
   end

   // edge table
   bps_ram #(
      .WIDTH ($bits(bps_pkg::link_type)),
      .DEPTH (bps_pkg::MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   // path stack
   bps_ram #(
      .WIDTH ($bits(bps_pkg::link_type)),
      .DEPTH (bps_pkg::MAX_EDGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

endmodule

// ----- sv/bps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bps_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bps_checker.sv -----
// Port-level checker for the backtracking path search, bound to the top level.
// Depends on bps_pkg and backtracking_path_search_top_macros.svh.
`include "backtracking_path_search_top_macros.svh"

module bps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bps_pkg::rsp_type rsp_data
);

   // a stalled result word holds
   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // no new command while results are going out
   `BPS_ASSERT_HOLDS(a_busy_on_rsp, clock, reset, rsp_valid, req_stall, "input open while a result is offered")

   // not-found word is a single, zeroed, final word
   `BPS_ASSERT_HOLDS(a_fail_form, clock, reset, rsp_valid && !rsp_data.found, rsp_data.last && (rsp_data.step_from == '0) && (rsp_data.step_to == '0), "malformed not-found word")

   // an accepted search makes the block busy
   `BPS_ASSERT_NEXT(a_search_busy, clock, reset, req_valid && !req_stall && (req_data.command == bps_pkg::CMD_SEARCH), req_stall, "input open right after a search")

endmodule

bind backtracking_path_search_top bps_checker u_bps_checker (.*);
